@@ hw/rtl/lsdde_pkg.sv @@
// Shared constants, types and helpers for the load step detect and decay estimate block.
`default_nettype none

package lsdde_pkg;

   // History ring
   localparam int HISTORY_DEPTH = 64;
   localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
   localparam int HIST_CW       = $clog2(HISTORY_DEPTH + 1);

   // Field widths
   localparam int TIME_W = 32;
   localparam int LOAD_W = 16;
   localparam int CSR_W  = 16;
   localparam int CSR_IW = 2;

   // Register reset values
   localparam logic [CSR_W-1:0] STEP_THRESHOLD_RST = CSR_W'(200);
   localparam logic [CSR_W-1:0] MAX_HISTORY_RST    = CSR_W'(60 * 60);
   localparam logic [CSR_W-1:0] MIN_HOLD_RST       = CSR_W'(2 * 60);

   // Register indexes
   localparam logic [CSR_IW-1:0] CSR_STEP_THRESHOLD = CSR_IW'(0);
   localparam logic [CSR_IW-1:0] CSR_MAX_HISTORY    = CSR_IW'(1);
   localparam logic [CSR_IW-1:0] CSR_MIN_HOLD       = CSR_IW'(2);

   // Command codes
   localparam logic CMD_READING = 1'b0;
   localparam logic CMD_QUERY   = 1'b1;

   // Serial divider sizing: 32-bit dividend, 16-bit divisor
   localparam int DIVIDEND_W = 2 * LOAD_W;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

   // Readings held before a step is judged
   localparam int RECENT_DEPTH = 3;

   // Step detector result
   typedef struct packed {
      logic              added;
      logic [LOAD_W-1:0] value;
      logic [TIME_W-1:0] time_s;
   } det_type;

   // Step a ring slot back by one, wrapping at the bottom
   function automatic logic [HIST_AW-1:0] slot_dec(input logic [HIST_AW-1:0] p);
      logic [HIST_AW-1:0] r;
      if (p == '0) begin
         r = HIST_AW'(HISTORY_DEPTH - 1);
      end else begin
         r = p - 1'b1;
      end
      return r;
   endfunction

   // Step a ring slot forward by one, wrapping at the top
   function automatic logic [HIST_AW-1:0] slot_inc(input logic [HIST_AW-1:0] p);
      logic [HIST_AW-1:0] r;
      if (p == HIST_AW'(HISTORY_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/lsdde_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none

module lsdde_div (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic [lsdde_pkg::DIVIDEND_W-1:0]   dividend,
   input  wire logic [lsdde_pkg::LOAD_W-1:0]       divisor,
   output logic                                    done,
   output logic [lsdde_pkg::LOAD_W-1:0]            quotient
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [lsdde_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [lsdde_pkg::LOAD_W-1:0]        rem_ff, rem_in;
   logic [lsdde_pkg::DIVIDEND_W-1:0]    quo_ff, quo_in;
   logic [lsdde_pkg::LOAD_W-1:0]        dsr_ff, dsr_in;
   logic [lsdde_pkg::LOAD_W:0]          trial;
   logic [lsdde_pkg::LOAD_W:0]          diff;
   logic                                fits;

   // Shift in the next dividend bit and try the subtract
   assign trial = {rem_ff, quo_ff[lsdde_pkg::DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[lsdde_pkg::LOAD_W-1:0] : trial[lsdde_pkg::LOAD_W-1:0];
         quo_in = {quo_ff[lsdde_pkg::DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == lsdde_pkg::DIV_CNT_W'(lsdde_pkg::DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[lsdde_pkg::LOAD_W-1:0];

endmodule

`default_nettype wire

@@ hw/rtl/lsdde_detect.sv @@
// Last three readings and the heavy-load step check.
`default_nettype none

module lsdde_detect (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            shift,
   input  wire logic [lsdde_pkg::TIME_W-1:0]    time_s,
   input  wire logic [lsdde_pkg::LOAD_W-1:0]    load_w,
   input  wire logic                            heavy_on,
   input  wire logic [lsdde_pkg::CSR_W-1:0]     threshold,
   output lsdde_pkg::det_type                   det
);

   logic [lsdde_pkg::LOAD_W-1:0] load_ff  [lsdde_pkg::RECENT_DEPTH];
   logic [lsdde_pkg::LOAD_W-1:0] load_in  [lsdde_pkg::RECENT_DEPTH];
   logic                         heavy_ff [lsdde_pkg::RECENT_DEPTH];
   logic                         heavy_in [lsdde_pkg::RECENT_DEPTH];
   logic [lsdde_pkg::TIME_W-1:0] time_ff  [lsdde_pkg::RECENT_DEPTH];
   logic [lsdde_pkg::TIME_W-1:0] time_in  [lsdde_pkg::RECENT_DEPTH];
   logic [1:0]                   cnt_ff, cnt_in;

   logic signed [lsdde_pkg::LOAD_W+1:0] d1, d2, th, neg_th, chosen;
   logic                                up, down, take1, take2;

   // Advance the three-reading window
   always_comb begin
      load_in  = load_ff;
      heavy_in = heavy_ff;
      time_in  = time_ff;
      cnt_in   = cnt_ff;
      if (shift) begin
         for (int i = 0; i < lsdde_pkg::RECENT_DEPTH - 1; i++) begin
            load_in[i]  = load_ff[i+1];
            heavy_in[i] = heavy_ff[i+1];
            time_in[i]  = time_ff[i+1];
         end
         load_in[lsdde_pkg::RECENT_DEPTH-1]  = load_w;
         heavy_in[lsdde_pkg::RECENT_DEPTH-1] = heavy_on;
         time_in[lsdde_pkg::RECENT_DEPTH-1]  = time_s;
         if (cnt_ff != 2'(lsdde_pkg::RECENT_DEPTH)) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lsdde_pkg::RECENT_DEPTH; i++) begin
            load_ff[i]  <= '0;
            heavy_ff[i] <= 1'b0;
            time_ff[i]  <= '0;
         end
         cnt_ff <= '0;
      end else begin
         load_ff  <= load_in;
         heavy_ff <= heavy_in;
         time_ff  <= time_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Judge the step: no lag first, then one-sample lag
   assign d1     = $signed({2'b00, load_ff[1]}) - $signed({2'b00, load_ff[0]});
   assign d2     = $signed({2'b00, load_ff[2]}) - $signed({2'b00, load_ff[0]});
   assign th     = $signed({2'b00, threshold});
   assign neg_th = -th;
   assign up     = !heavy_ff[0] && heavy_ff[1];
   assign down   = heavy_ff[0] && !heavy_ff[1];
   assign take1  = (up && (d1 > th)) || (down && (d1 < neg_th));
   assign take2  = (up && (d2 > th)) || (down && (d2 < neg_th));
   assign chosen = take1 ? d1 : d2;

   always_comb begin
      det.added  = (cnt_ff == 2'(lsdde_pkg::RECENT_DEPTH)) && (take1 || take2);
      det.value  = chosen[lsdde_pkg::LOAD_W+1] ? lsdde_pkg::LOAD_W'(-chosen)
                                               : chosen[lsdde_pkg::LOAD_W-1:0];
      det.time_s = time_ff[1];
   end

endmodule

`default_nettype wire

@@ hw/rtl/load_step_detect_and_decay_estimate_top.sv @@
// Top level: sequencer, history ring and result register of the step estimator.
//
//  channel | ports                                    | dir | moves
//  --------+------------------------------------------+-----+---------------------------
//  req     | req_valid req_stall req_cmd req_time_s   | in  | one reading or query beat
//          | req_load_w req_heavy_on                  |     |
//  rsp     | rsp_valid rsp_stall rsp_sample_added     | out | one result beat per request
//          | rsp_sample_value_w rsp_estimate_w        |     |
//  csr     | csr_wr_en csr_index csr_wdata            | in  | register write, no read-back
//
// A reading is a window shift, then the step check and history write.
// A query walks the history at one read per cycle (up to 62 entries walked),
// then computes the estimate with the 32-step serial divider.
// One beat is in flight at a time; req_stall is high while it is worked on.
// Synchronous reset clears control state; the history ring is not cleared.
// rsp_stall holds the result register; a new beat is taken as it drains.
`default_nettype none

module load_step_detect_and_decay_estimate_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_cmd,
   input  wire logic [lsdde_pkg::TIME_W-1:0]     req_time_s,
   input  wire logic [lsdde_pkg::LOAD_W-1:0]     req_load_w,
   input  wire logic                             req_heavy_on,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_sample_added,
   output logic [lsdde_pkg::LOAD_W-1:0]          rsp_sample_value_w,
   output logic [lsdde_pkg::LOAD_W-1:0]          rsp_estimate_w,
   input  wire logic                             csr_wr_en,
   input  wire logic [lsdde_pkg::CSR_IW-1:0]     csr_index,
   input  wire logic [lsdde_pkg::CSR_W-1:0]      csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_NEWEST,
      ST_WALK,
      ST_SPAN,
      ST_DIST,
      ST_MUL,
      ST_DIV_GO,
      ST_DIV_WAIT
   } state_type;

   state_type                        state_ff, state_in;

   // Registers
   logic [lsdde_pkg::CSR_W-1:0]      thr_ff, thr_in;
   logic [lsdde_pkg::CSR_W-1:0]      maxh_ff, maxh_in;
   logic [lsdde_pkg::CSR_W-1:0]      minh_ff, minh_in;

   // History ring control
   logic [lsdde_pkg::HIST_AW-1:0]    head_ff, head_in;
   logic [lsdde_pkg::HIST_CW-1:0]    count_ff, count_in;
   logic [lsdde_pkg::HIST_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [lsdde_pkg::HIST_CW-1:0]    walk_ff, walk_in;

   // Query working values
   logic [lsdde_pkg::TIME_W-1:0]     now_ff, now_in;
   logic [lsdde_pkg::TIME_W-1:0]     last_t_ff, last_t_in;
   logic [lsdde_pkg::LOAD_W-1:0]     last_v_ff, last_v_in;
   logic [lsdde_pkg::TIME_W-1:0]     pass_t_ff, pass_t_in;
   logic [lsdde_pkg::LOAD_W-1:0]     span_ff, span_in;
   logic [lsdde_pkg::LOAD_W-1:0]     mulb_ff, mulb_in;
   logic [lsdde_pkg::DIVIDEND_W-1:0] prod_ff, prod_in;

   // Result register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_added_ff, rsp_added_in;
   logic [lsdde_pkg::LOAD_W-1:0]     rsp_value_ff, rsp_value_in;
   logic [lsdde_pkg::LOAD_W-1:0]     rsp_est_ff, rsp_est_in;

   // History memory
   logic [lsdde_pkg::TIME_W-1:0]     hist_time_mem  [lsdde_pkg::HISTORY_DEPTH];
   logic [lsdde_pkg::LOAD_W-1:0]     hist_value_mem [lsdde_pkg::HISTORY_DEPTH];
   logic [lsdde_pkg::TIME_W-1:0]     rd_time_ff;
   logic [lsdde_pkg::LOAD_W-1:0]     rd_value_ff;
   logic                             wr_en;

   logic                             req_take;
   logic                             det_shift;
   lsdde_pkg::det_type               det;
   logic                             div_start, div_done;
   logic [lsdde_pkg::LOAD_W-1:0]     div_quo;

   logic signed [lsdde_pkg::TIME_W:0]   now_age, walk_age, span_raw;
   logic signed [lsdde_pkg::TIME_W:0]   maxh_s, minh_s;
   logic signed [lsdde_pkg::TIME_W+1:0] d_raw;
   logic [lsdde_pkg::TIME_W+1:0]        end_t;
   logic [lsdde_pkg::LOAD_W+1:0]        walk_v4, last_v3;
   logic                                walk_stop;

   lsdde_detect u_detect (
      .clock     (clock),
      .reset     (reset),
      .shift     (det_shift),
      .time_s    (req_time_s),
      .load_w    (req_load_w),
      .heavy_on  (req_heavy_on),
      .threshold (thr_ff),
      .det       (det)
   );

   lsdde_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (span_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Take a beat only when idle and the result register is free by this edge
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_take  = req_valid && !req_stall;
   assign det_shift = req_take && (req_cmd == lsdde_pkg::CMD_READING);
   assign div_start = (state_ff == ST_DIV_GO);
   assign wr_en     = (state_ff == ST_CHECK) && det.added;

   // Age and walk compares
   assign maxh_s    = $signed({17'd0, maxh_ff});
   assign minh_s    = $signed({17'd0, minh_ff});
   assign now_age   = $signed({1'b0, now_ff}) - $signed({1'b0, rd_time_ff});
   assign walk_age  = $signed({1'b0, last_t_ff}) - $signed({1'b0, rd_time_ff});
   assign walk_v4   = {rd_value_ff, 2'b00};
   assign last_v3   = {2'b00, last_v_ff} + {1'b0, last_v_ff, 1'b0};
   assign walk_stop = (walk_v4 < last_v3) || (walk_age > maxh_s);
   assign span_raw  = $signed({1'b0, last_t_ff}) - $signed({1'b0, pass_t_ff});
   assign end_t     = {2'b00, last_t_ff} + {18'd0, span_ff};
   assign d_raw     = $signed({2'b00, now_ff}) - $signed(end_t);

   always_comb begin
      state_in     = state_ff;
      thr_in       = thr_ff;
      maxh_in      = maxh_ff;
      minh_in      = minh_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      rd_ptr_in    = rd_ptr_ff;
      walk_in      = walk_ff;
      now_in       = now_ff;
      last_t_in    = last_t_ff;
      last_v_in    = last_v_ff;
      pass_t_in    = pass_t_ff;
      span_in      = span_ff;
      mulb_in      = mulb_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_added_in = rsp_added_ff;
      rsp_value_in = rsp_value_ff;
      rsp_est_in   = rsp_est_ff;

      // Register writes
      if (csr_wr_en) begin
         case (csr_index)
            lsdde_pkg::CSR_STEP_THRESHOLD: thr_in  = csr_wdata;
            lsdde_pkg::CSR_MAX_HISTORY:    maxh_in = csr_wdata;
            lsdde_pkg::CSR_MIN_HOLD:       minh_in = csr_wdata;
            default:                       thr_in  = thr_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               now_in = req_time_s;
               if (req_cmd == lsdde_pkg::CMD_READING) begin
                  state_in = ST_CHECK;
               end else if (count_ff == '0) begin
                  // Empty history: answer zero at once
                  rsp_valid_in = 1'b1;
                  rsp_added_in = 1'b0;
                  rsp_value_in = '0;
                  rsp_est_in   = '0;
               end else begin
                  rd_ptr_in = lsdde_pkg::slot_dec(head_ff);
                  state_in  = ST_NEWEST;
               end
            end
         end
         ST_CHECK: begin
            // Append the step, overwriting the oldest entry when full
            if (det.added) begin
               head_in = lsdde_pkg::slot_inc(head_ff);
               if (count_ff != lsdde_pkg::HIST_CW'(lsdde_pkg::HISTORY_DEPTH)) begin
                  count_in = count_ff + 1'b1;
               end
            end
            rsp_valid_in = 1'b1;
            rsp_added_in = det.added;
            rsp_value_in = det.added ? det.value : '0;
            rsp_est_in   = '0;
            state_in     = ST_IDLE;
         end
         ST_NEWEST: begin
            last_t_in = rd_time_ff;
            last_v_in = rd_value_ff;
            pass_t_in = rd_time_ff;
            if (now_age > maxh_s) begin
               // Stale newest entry
               rsp_valid_in = 1'b1;
               rsp_added_in = 1'b0;
               rsp_value_in = '0;
               rsp_est_in   = '0;
               state_in     = ST_IDLE;
            end else if (count_ff > lsdde_pkg::HIST_CW'(2)) begin
               rd_ptr_in = lsdde_pkg::slot_dec(rd_ptr_ff);
               walk_in   = lsdde_pkg::HIST_CW'(2);
               state_in  = ST_WALK;
            end else begin
               state_in = ST_SPAN;
            end
         end
         ST_WALK: begin
            // One entry per cycle, never reaching the oldest
            if (walk_stop) begin
               state_in = ST_SPAN;
            end else begin
               pass_t_in = rd_time_ff;
               if ((walk_ff + 1'b1) < count_ff) begin
                  walk_in   = walk_ff + 1'b1;
                  rd_ptr_in = lsdde_pkg::slot_dec(rd_ptr_ff);
               end else begin
                  state_in = ST_SPAN;
               end
            end
         end
         ST_SPAN: begin
            // Raise to min hold, lower to max history, never below one
            if (span_raw < minh_s) begin
               span_in = minh_ff;
            end else if (span_raw > maxh_s) begin
               span_in = maxh_ff;
            end else begin
               span_in = span_raw[lsdde_pkg::LOAD_W-1:0];
            end
            if ((span_raw < minh_s) && (minh_ff > maxh_ff)) begin
               span_in = maxh_ff;
            end
            if (span_in == '0) begin
               span_in = lsdde_pkg::LOAD_W'(1);
            end
            state_in = ST_DIST;
         end
         ST_DIST: begin
            // Decay distance clamped to the span
            if (d_raw < 0) begin
               mulb_in = span_ff;
            end else if (d_raw > $signed({18'd0, span_ff})) begin
               mulb_in = '0;
            end else begin
               mulb_in = span_ff - d_raw[lsdde_pkg::LOAD_W-1:0];
            end
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = last_v_ff * mulb_ff;
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               rsp_valid_in = 1'b1;
               rsp_added_in = 1'b0;
               rsp_value_in = '0;
               rsp_est_in   = div_quo;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         thr_ff       <= lsdde_pkg::STEP_THRESHOLD_RST;
         maxh_ff      <= lsdde_pkg::MAX_HISTORY_RST;
         minh_ff      <= lsdde_pkg::MIN_HOLD_RST;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         maxh_ff      <= maxh_in;
         minh_ff      <= minh_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_ptr_ff    <= rd_ptr_in;
      walk_ff      <= walk_in;
      now_ff       <= now_in;
      last_t_ff    <= last_t_in;
      last_v_ff    <= last_v_in;
      pass_t_ff    <= pass_t_in;
      span_ff      <= span_in;
      mulb_ff      <= mulb_in;
      prod_ff      <= prod_in;
      rsp_added_ff <= rsp_added_in;
      rsp_value_ff <= rsp_value_in;
      rsp_est_ff   <= rsp_est_in;
   end

   // History ring: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_time_mem[head_ff]  <= det.time_s;
         hist_value_mem[head_ff] <= det.value;
      end
      rd_time_ff  <= hist_time_mem[rd_ptr_in];
      rd_value_ff <= hist_value_mem[rd_ptr_in];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample_added   = rsp_added_ff;
   assign rsp_sample_value_w = rsp_value_ff;
   assign rsp_estimate_w     = rsp_est_ff;

   // The fill count never passes the ring depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= lsdde_pkg::HIST_CW'(lsdde_pkg::HISTORY_DEPTH))
      else $error("history count beyond ring depth");

   // A stalled result beat holds until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_sample_added)
         && $stable(rsp_sample_value_w) && $stable(rsp_estimate_w)))
      else $error("stalled result beat changed");

   // The walk stays below the fill count
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (walk_ff < count_ff))
      else $error("walk beyond held entries");

   // Divider finishes only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_WAIT))
      else $error("divider finished outside wait state");

   // A query never starts on an empty ring
   a_query_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NEWEST) |-> (count_ff != '0))
      else $error("history read on empty ring");

endmodule

`default_nettype wire
